// ===== hdl/sdc_pkg.sv =====
// ============================================================================
// sdc_pkg
// Shared constants and types for the stopping distance calculator.
// ============================================================================
`default_nettype none

package sdc_pkg;

    localparam int POINTS_PER_CONDITION = 8;
    localparam int CONDITIONS           = 4;
    localparam int TOTAL_POINTS         = CONDITIONS * POINTS_PER_CONDITION;
    localparam int ADDR_W               = $clog2(TOTAL_POINTS);
    localparam int SLOT_BITS            = $clog2(POINTS_PER_CONDITION);
    localparam int SCAN_W               = $clog2(POINTS_PER_CONDITION + 1);

    // divider width
    localparam int DIV_W   = 64;
    localparam int DIV_C_W = $clog2(DIV_W + 1);

    // request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // config register indexes
    localparam logic CFG_ROAD  = 1'b0;
    localparam logic CFG_REACT = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_STATIONARY = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;
    localparam logic [1:0] ST_NO_DECEL   = 2'd3;

    // arithmetic constants
    localparam logic [29:0] K_DIST_NUM = 30'd1024000000; // distance numerator
    localparam logic [15:0] K_DIST_DEN = 16'd39771;
    localparam logic [19:0] K_TIME_NUM = 20'd1000000;    // times 2^19
    localparam logic [12:0] K_TIME_DEN = 13'd4419;
    localparam logic [22:0] K_RECIP9   = 23'd7456541;    // ceil(2^26 / 9)

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_SCAN      = 13'b0000000000010,
        S_SEG       = 13'b0000000000100,
        S_MU_GO     = 13'b0000000001000,
        S_MU_WAIT   = 13'b0000000010000,
        S_DECEL     = 13'b0000000100000,
        S_BRAKE     = 13'b0000001000000,
        S_DEN       = 13'b0000010000000,
        S_DEN_SUM   = 13'b0000100000000,
        S_DIST_GO   = 13'b0001000000000,
        S_DIST_WAIT = 13'b0010000000000,
        S_TIME_GO   = 13'b0100000000000,
        S_TIME_WAIT = 13'b1000000000000
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/sdc_div.sv =====
// ============================================================================
// sdc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module sdc_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [sdc_pkg::DIV_W-1:0] num,
    input  wire logic [sdc_pkg::DIV_W-1:0] den,
    output logic                          done,
    output logic [sdc_pkg::DIV_W-1:0]     quot
);

    logic                          run_reg;
    logic                          done_reg;
    logic [sdc_pkg::DIV_C_W-1:0]   cnt_reg;
    logic [sdc_pkg::DIV_W:0]       rem_reg;
    logic [sdc_pkg::DIV_W-1:0]     quo_reg;
    logic [sdc_pkg::DIV_W-1:0]     den_reg;
    logic [sdc_pkg::DIV_W:0]       rem_sh;
    logic                          fits;

    assign rem_sh = {rem_reg[sdc_pkg::DIV_W-1:0], quo_reg[sdc_pkg::DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == sdc_pkg::DIV_C_W'(sdc_pkg::DIV_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[sdc_pkg::DIV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/stopping_distance_calc.sv =====
// ============================================================================
// stopping_distance_calc
// Stopping distance and time from a piecewise linear friction table.
// ============================================================================
// A table write's result (all zero, status ok) shows with done in the
// next cycle and busy never rises. A query that ends early (stationary or
// empty table) also answers in the next cycle. A full query scans the
// active table memory (one slot read per cycle), then runs up to three 64
// step divisions on one shared restoring divider (coefficient interpolation,
// braking distance, braking time). busy is high while a query is in work;
// start is ignored then. done is a one cycle strobe and the receiver cannot
// stall it; the result fields hold until the next request is accepted. No
// clearing pass is needed after reset; valid bits live in flops.
// ============================================================================
`default_nettype none

module stopping_distance_calc (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               kind,
    input  wire logic [1:0]         table_condition,
    input  wire logic [2:0]         table_slot,
    input  wire logic [15:0]        entry_velocity,
    input  wire logic [14:0]        coefficient,
    input  wire logic               entry_valid,
    input  wire logic [15:0]        speed,
    input  wire logic signed [15:0] slope_sine,
    input  wire logic [14:0]        slope_cosine,
    // result
    output logic                    done,
    output logic [31:0]             stop_distance,
    output logic [31:0]             stop_time,
    output logic [1:0]              status,
    // config
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [13:0]        cfg_data
);

    localparam int P  = sdc_pkg::POINTS_PER_CONDITION;
    localparam int AW = sdc_pkg::ADDR_W;

    sdc_pkg::state_t state_reg;

    // config registers
    logic [1:0]  road_condition_reg;
    logic [13:0] reaction_time_reg;

    // table: speed and coefficient in memory, valid bits in flops
    logic [30:0]                      tbl_mem [sdc_pkg::TOTAL_POINTS];
    logic [30:0]                      rd_data_reg;
    logic [sdc_pkg::TOTAL_POINTS-1:0] valid_reg;
    logic [AW-1:0]                    wr_idx;
    logic [AW-1:0]                    rd_idx;
    logic                             wr_in_range;
    logic                             mem_we;
    logic                             tbl_any;

    // request latch
    logic [15:0]        v_reg;
    logic signed [15:0] sn_reg;
    logic [14:0]        cs_reg;

    // scan
    logic [sdc_pkg::SCAN_W-1:0] scan_idx_reg;
    logic                       rd_hit_reg;
    logic                       have_one_reg;
    logic                       have_two_reg;
    logic                       found_reg;
    logic [15:0]                sb_reg, sa_reg;
    logic [14:0]                cb_reg, ca_reg;

    // interpolation
    logic signed [15:0] dc;
    logic signed [16:0] dv;
    logic signed [16:0] vd;
    logic signed [32:0] prod_reg;
    logic signed [16:0] dv_reg;
    logic               neg_reg;
    logic [31:0]        mu_reg;
    logic signed [33:0] q_signed;
    logic signed [33:0] mu_sum;

    // deceleration and braking terms
    logic [46:0]        mc_reg;
    logic [31:0]        vv_reg;
    logic [29:0]        vrt_reg;
    logic signed [48:0] d_sum;
    logic [47:0]        d_reg;
    logic [61:0]        num_dist_reg;
    logic [54:0]        num_time_reg;
    logic [21:0]        rq_in_reg;
    logic [39:0]        pl_d_reg, ph_d_reg;
    logic [36:0]        pl_t_reg, ph_t_reg;
    logic [44:0]        rq_reg;
    logic [63:0]        den_dist_reg, den_time_reg;
    logic [18:0]        rdist_reg;
    logic [64:0]        dist_sum;
    logic [64:0]        time_sum;

    // divider
    logic                       div_start;
    logic [sdc_pkg::DIV_W-1:0]  div_num;
    logic [sdc_pkg::DIV_W-1:0]  div_den;
    logic                       div_done;
    logic [sdc_pkg::DIV_W-1:0]  div_quot;

    // result
    logic        done_reg;
    logic [31:0] dist_out_reg;
    logic [31:0] time_out_reg;
    logic [1:0]  status_reg;

    logic accept;

    assign busy   = (state_reg != sdc_pkg::S_IDLE);
    assign accept = start && !busy;

    assign wr_in_range = (32'(table_condition) < sdc_pkg::CONDITIONS) &&
                         (32'(table_slot) < P);
    assign wr_idx = AW'(32'(table_condition) * P + 32'(table_slot));
    assign mem_we = accept && (kind == sdc_pkg::KIND_WRITE) && wr_in_range && entry_valid;
    assign rd_idx = AW'(32'(road_condition_reg) * P +
                        32'(scan_idx_reg[sdc_pkg::SLOT_BITS-1:0]));

    // any valid point in the active table
    always_comb
    begin
        tbl_any = 1'b0;
        if (32'(road_condition_reg) < sdc_pkg::CONDITIONS)
        begin
            for (int k = 0; k < P; k++)
            begin
                tbl_any = tbl_any | valid_reg[AW'(32'(road_condition_reg) * P + k)];
            end
        end
    end

    // synchronous table memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[wr_idx] <= {entry_velocity, coefficient};
        end
        rd_data_reg <= tbl_mem[rd_idx];
    end

    // segment arithmetic
    assign dc = $signed({1'b0, ca_reg}) - $signed({1'b0, cb_reg});
    assign dv = $signed({1'b0, sa_reg}) - $signed({1'b0, sb_reg});
    assign vd = $signed({1'b0, v_reg}) - $signed({1'b0, sb_reg});

    assign q_signed = neg_reg ? -$signed({2'b00, div_quot[31:0]})
                              :  $signed({2'b00, div_quot[31:0]});
    assign mu_sum   = $signed({19'd0, cb_reg}) + q_signed;

    // D = mu*cos + sin*2^14
    assign d_sum = $signed({2'b00, mc_reg}) + $signed({{19{sn_reg[15]}}, sn_reg, 14'd0});

    assign dist_sum = {1'b0, div_quot} + 65'(rdist_reg);
    assign time_sum = {1'b0, div_quot} + 65'(reaction_time_reg);

    // divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            sdc_pkg::S_MU_GO:
            begin
                div_start = 1'b1;
                div_num   = 64'(prod_reg[32] ? -prod_reg : prod_reg);
                div_den   = 64'(dv_reg[16] ? -dv_reg : dv_reg);
            end
            sdc_pkg::S_DIST_GO:
            begin
                div_start = 1'b1;
                div_num   = 64'(num_dist_reg);
                div_den   = den_dist_reg;
            end
            sdc_pkg::S_TIME_GO:
            begin
                div_start = 1'b1;
                div_num   = 64'(num_time_reg);
                div_den   = den_time_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    sdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            road_condition_reg <= 2'd3;
            reaction_time_reg  <= 14'd1250;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sdc_pkg::CFG_ROAD:  road_condition_reg <= cfg_data[1:0];
                sdc_pkg::CFG_REACT: reaction_time_reg  <= cfg_data;
                default:            road_condition_reg <= road_condition_reg;
            endcase
        end
    end

    // control: sequencer, valid bits, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sdc_pkg::S_IDLE;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            scan_idx_reg <= '0;
            rd_hit_reg   <= 1'b0;
            have_one_reg <= 1'b0;
            have_two_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                sdc_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        if (kind == sdc_pkg::KIND_WRITE)
                        begin
                            if (wr_in_range)
                            begin
                                valid_reg[wr_idx] <= entry_valid;
                            end
                            done_reg <= 1'b1;
                        end
                        else if (speed == 16'd0 || !tbl_any)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg    <= sdc_pkg::S_SCAN;
                            scan_idx_reg <= '0;
                            rd_hit_reg   <= 1'b0;
                            have_one_reg <= 1'b0;
                            have_two_reg <= 1'b0;
                            found_reg    <= 1'b0;
                        end
                    end
                end
                sdc_pkg::S_SCAN:
                begin
                    // read slot in flight; hit flag is registered alongside the data
                    if (scan_idx_reg == sdc_pkg::SCAN_W'(P))
                    begin
                        rd_hit_reg <= 1'b0;
                        state_reg  <= sdc_pkg::S_SEG;
                    end
                    else
                    begin
                        rd_hit_reg   <= valid_reg[rd_idx];
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (rd_hit_reg)
                    begin
                        if (!have_one_reg)
                        begin
                            have_one_reg <= 1'b1;
                        end
                        else if (!found_reg)
                        begin
                            have_two_reg <= 1'b1;
                            if (rd_data_reg[30:15] >= v_reg)
                            begin
                                found_reg <= 1'b1;
                            end
                        end
                    end
                end
                sdc_pkg::S_SEG:
                begin
                    if (!have_two_reg || dv == 17'sd0)
                    begin
                        state_reg <= sdc_pkg::S_DECEL;
                    end
                    else
                    begin
                        state_reg <= sdc_pkg::S_MU_GO;
                    end
                end
                sdc_pkg::S_MU_GO:
                begin
                    state_reg <= sdc_pkg::S_MU_WAIT;
                end
                sdc_pkg::S_MU_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= sdc_pkg::S_DECEL;
                    end
                end
                sdc_pkg::S_DECEL:
                begin
                    state_reg <= sdc_pkg::S_BRAKE;
                end
                sdc_pkg::S_BRAKE:
                begin
                    if (d_sum <= 49'sd0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= sdc_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_reg <= sdc_pkg::S_DEN;
                    end
                end
                sdc_pkg::S_DEN:
                begin
                    state_reg <= sdc_pkg::S_DEN_SUM;
                end
                sdc_pkg::S_DEN_SUM:
                begin
                    state_reg <= sdc_pkg::S_DIST_GO;
                end
                sdc_pkg::S_DIST_GO:
                begin
                    state_reg <= sdc_pkg::S_DIST_WAIT;
                end
                sdc_pkg::S_DIST_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= sdc_pkg::S_TIME_GO;
                    end
                end
                sdc_pkg::S_TIME_GO:
                begin
                    state_reg <= sdc_pkg::S_TIME_WAIT;
                end
                sdc_pkg::S_TIME_WAIT:
                begin
                    if (div_done)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= sdc_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= sdc_pkg::S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sdc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    v_reg  <= speed;
                    sn_reg <= slope_sine;
                    cs_reg <= slope_cosine;
                    if (kind == sdc_pkg::KIND_WRITE)
                    begin
                        dist_out_reg <= '0;
                        time_out_reg <= '0;
                        status_reg   <= sdc_pkg::ST_OK;
                    end
                    else if (speed == 16'd0)
                    begin
                        dist_out_reg <= '0;
                        time_out_reg <= '0;
                        status_reg   <= sdc_pkg::ST_STATIONARY;
                    end
                    else
                    begin
                        dist_out_reg <= sdc_pkg::SAT32;
                        time_out_reg <= sdc_pkg::SAT32;
                        status_reg   <= sdc_pkg::ST_EMPTY;
                    end
                end
            end
            sdc_pkg::S_SCAN:
            begin
                // keep lower/upper points of the segment
                if (rd_hit_reg)
                begin
                    if (!have_one_reg)
                    begin
                        sa_reg <= rd_data_reg[30:15];
                        ca_reg <= rd_data_reg[14:0];
                    end
                    else if (!found_reg)
                    begin
                        sb_reg <= sa_reg;
                        cb_reg <= ca_reg;
                        sa_reg <= rd_data_reg[30:15];
                        ca_reg <= rd_data_reg[14:0];
                    end
                end
            end
            sdc_pkg::S_SEG:
            begin
                mu_reg   <= 32'(ca_reg);
                prod_reg <= dc * vd;
                dv_reg   <= dv;
                neg_reg  <= dc[15] ^ vd[16] ^ dv[16];
            end
            sdc_pkg::S_MU_WAIT:
            begin
                if (div_done)
                begin
                    mu_reg <= mu_sum[33] ? 32'd0 : mu_sum[31:0];
                end
            end
            sdc_pkg::S_DECEL:
            begin
                mc_reg  <= mu_reg * cs_reg;
                vv_reg  <= v_reg * v_reg;
                vrt_reg <= v_reg * reaction_time_reg;
            end
            sdc_pkg::S_BRAKE:
            begin
                d_reg        <= d_sum[47:0];
                num_dist_reg <= sdc_pkg::K_DIST_NUM * vv_reg;
                num_time_reg <= {36'(sdc_pkg::K_TIME_NUM) * 36'(v_reg), 19'd0};
                rq_in_reg    <= vrt_reg[29:8];
                if (d_sum <= 49'sd0)
                begin
                    dist_out_reg <= sdc_pkg::SAT32;
                    time_out_reg <= sdc_pkg::SAT32;
                    status_reg   <= sdc_pkg::ST_NO_DECEL;
                end
            end
            sdc_pkg::S_DEN:
            begin
                // 48-bit D split in two 24-bit halves
                pl_d_reg <= sdc_pkg::K_DIST_DEN * d_reg[23:0];
                ph_d_reg <= sdc_pkg::K_DIST_DEN * d_reg[47:24];
                pl_t_reg <= sdc_pkg::K_TIME_DEN * d_reg[23:0];
                ph_t_reg <= sdc_pkg::K_TIME_DEN * d_reg[47:24];
                rq_reg   <= rq_in_reg * sdc_pkg::K_RECIP9;
            end
            sdc_pkg::S_DEN_SUM:
            begin
                den_dist_reg <= 64'(pl_d_reg) + {ph_d_reg, 24'd0};
                den_time_reg <= 64'(pl_t_reg) + 64'({ph_t_reg, 24'd0});
                rdist_reg    <= rq_reg[44:26];
            end
            sdc_pkg::S_DIST_WAIT:
            begin
                if (div_done)
                begin
                    dist_out_reg <= (dist_sum[64:32] != '0) ? sdc_pkg::SAT32 : dist_sum[31:0];
                end
            end
            sdc_pkg::S_TIME_WAIT:
            begin
                if (div_done)
                begin
                    time_out_reg <= (time_sum[64:32] != '0) ? sdc_pkg::SAT32 : time_sum[31:0];
                    status_reg   <= sdc_pkg::ST_OK;
                end
            end
            default:
            begin
                mu_reg <= mu_reg;
            end
        endcase
    end

    assign done          = done_reg;
    assign stop_distance = dist_out_reg;
    assign stop_time     = time_out_reg;
    assign status        = status_reg;

endmodule

`default_nettype wire

// ===== hdl/sdc_chk.sv =====
// ============================================================================
// sdc_chk
// Port level checks for the stopping distance calculator.
// ============================================================================
`default_nettype none

module sdc_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        kind,
    input wire logic        done,
    input wire logic [31:0] stop_distance,
    input wire logic [31:0] stop_time,
    input wire logic [1:0]  status
);

    // busy only follows a request
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // a result ends the work
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // a write answers in the next cycle
    a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == sdc_pkg::KIND_WRITE) |=>
            (done && !busy && status == sdc_pkg::ST_OK && stop_distance == 32'd0))
        else $error("write result missing");

    // error results saturate
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sdc_pkg::ST_EMPTY || status == sdc_pkg::ST_NO_DECEL)) |->
            (stop_distance == sdc_pkg::SAT32 && stop_time == sdc_pkg::SAT32))
        else $error("error result not saturated");

    // stationary gives zeros
    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sdc_pkg::ST_STATIONARY) |->
            (stop_distance == 32'd0 && stop_time == 32'd0))
        else $error("stationary result not zero");

endmodule

bind stopping_distance_calc sdc_chk u_sdc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .done          (done),
    .stop_distance (stop_distance),
    .stop_time     (stop_time),
    .status        (status)
);

`default_nettype wire
